FILE: rtl/hfd_pkg.sv
// ----------------------------------------------------------------------------
// Hex float to double package
// Shared widths and constants for the hex-real to binary64 converter.
// ----------------------------------------------------------------------------
package hfd_pkg;

   localparam int unsigned WORD_W   = 64;
   localparam int unsigned FRAC_W   = 56;
   localparam int unsigned LEAD_W   = 6;
   localparam int unsigned BEXP_W   = 11;
   localparam int unsigned MANT_W   = 52;

   // Exponent offset: biased exponent = EXP_OFS + 4*hexp - lzc, with the
   // fraction left-aligned to 56 bits (1023 - 1 - 256)
   localparam int unsigned EXP_OFS  = 1023 - 1 - 256;

   typedef logic [WORD_W-1:0] word_type;

   typedef struct packed {
      logic              sign;
      logic [6:0]        hexp;
      logic [FRAC_W-1:0] frac;   // left-aligned to 56 bits
      logic              zero;
   } unpack_type;

   typedef struct packed {
      logic              sign;
      logic [6:0]        hexp;
      logic [LEAD_W-1:0] lzc;    // leading zeros of the 56-bit fraction
      logic [FRAC_W-1:0] frac;
      logic              zero;
   } count_type;

   typedef struct packed {
      logic              sign;
      logic [BEXP_W-1:0] bexp;
      logic [FRAC_W-1:0] norm;   // leading one at top bit
      logic              zero;
   } norm_type;

endpackage

FILE: rtl/hfd_stream_if.sv
// ----------------------------------------------------------------------------
// Stream interface
// Valid/ready channel with a parameterised payload.
// ----------------------------------------------------------------------------
interface hfd_stream_if #(
   parameter int unsigned DATA_W = 65
);
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/hex_float_to_ieee_double_unit.sv
// ----------------------------------------------------------------------------
// Hex float to IEEE double unit
// Converts one GDSII hex real (4 or 8 bytes) to a binary64 bit pattern.
// ----------------------------------------------------------------------------
// One word is accepted per cycle while the output is not stalled; a word taken
// at a rising edge passes through the stage registers s1, s2, s3 and s4 and
// shows on the output once it reaches s4. Stages: unpack, leading-zero count,
// normalising shift with exponent, round and pack. Each stage holds its word
// while the next stage is stalled; ready follows the output.
module hex_float_to_ieee_double_unit (
   input logic clock,
   input logic reset,
   hfd_stream_if.sink   req,
   hfd_stream_if.source rsp
);
   import hfd_pkg::*;

   logic       v1_ff, v2_ff, v3_ff, v4_ff;
   logic       adv1, adv2, adv3, adv4;
   unpack_type s1_ff, s1_in;
   count_type  s2_ff, s2_in;
   norm_type   s3_ff, s3_in;
   word_type   s4_ff, s4_in;

   // Advance each stage when its successor has room
   assign adv4 = !v4_ff || rsp.ready;
   assign adv3 = !v3_ff || adv4;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign req.ready = adv1;
   assign rsp.valid = v4_ff;
   assign rsp.data  = s4_ff;

   // Unpack the word into sign, exponent and left-aligned fraction
   always_comb begin
      logic       kind;
      logic [63:0] w;
      kind = req.data[64];
      w    = req.data[63:0];
      if (kind) begin
         s1_in.sign = w[63];
         s1_in.hexp = w[62:56];
         s1_in.frac = w[55:0];
      end else begin
         s1_in.sign = w[31];
         s1_in.hexp = w[30:24];
         s1_in.frac = {w[23:0], 32'd0};
      end
      s1_in.zero = (s1_in.frac == '0);
   end

   // Count leading zeros of the fraction
   always_comb begin
      s2_in.sign = s1_ff.sign;
      s2_in.hexp = s1_ff.hexp;
      s2_in.frac = s1_ff.frac;
      s2_in.zero = s1_ff.zero;
      s2_in.lzc  = '0;
      for (int i = 0; i < FRAC_W; i++) begin
         if (s1_ff.frac[i]) s2_in.lzc = LEAD_W'(FRAC_W - 1 - i);
      end
   end

   // Shift the leading one to the top and form the biased exponent
   always_comb begin
      s3_in.sign = s2_ff.sign;
      s3_in.zero = s2_ff.zero;
      s3_in.norm = s2_ff.frac << s2_ff.lzc;
      s3_in.bexp = BEXP_W'(EXP_OFS) + BEXP_W'({s2_ff.hexp, 2'b00})
                   - BEXP_W'(s2_ff.lzc);
   end

   // Round to nearest even and pack
   always_comb begin
      logic [53:0] m;
      logic        g, st;
      logic [BEXP_W-1:0] e;
      g  = s3_ff.norm[2];
      st = |s3_ff.norm[1:0];
      m  = {1'b0, s3_ff.norm[55:3]};
      if (g && (st || m[0])) m = m + 54'd1;
      e = s3_ff.bexp;
      if (m[53]) begin
         m = m >> 1;
         e = e + BEXP_W'(1);
      end
      if (s3_ff.zero) s4_in = {s3_ff.sign, 63'd0};
      else            s4_in = {s3_ff.sign, e, m[MANT_W-1:0]};
   end

   // Hold or advance stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; v4_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= req.valid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
         if (adv4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) s1_ff <= s1_in;
      if (adv2) s2_ff <= s2_in;
      if (adv3) s3_ff <= s3_in;
      if (adv4) s4_ff <= s4_in;
   end

endmodule

FILE: rtl/hfd_checker.sv
// ----------------------------------------------------------------------------
// Hex float converter checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module hfd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [64:0] req_data,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_data
);
   // Result word holds while stalled
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed under stall");

   // No result right after reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // Input taken whenever output drains
   assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("input blocked while output drains");

   // Zero input word gives +0 at the output when the output does not stall
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data[63:0] == 64'd0 && rsp_ready
      ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready |=> rsp_valid && rsp_data == 64'd0)
      else $error("zero word not converted to +0");
endmodule

bind hex_float_to_ieee_double_unit hfd_checker u_hfd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .req_data  (req.data),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_data  (rsp.data)
);
